// ===== sv/int64_to_decimal_ascii_top_defines.svh =====
// Assertion macros shared by the integer-to-decimal text block.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef INT64_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INT64_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define I64DA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define I64DA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i64da_pkg.sv =====
// Shared constants and types for the integer-to-decimal text block.
// No dependencies.
`default_nettype none

package i64da_pkg;

    localparam int INPUT_WIDTH  = 64;
    localparam int VALUE_WIDTH  = 64;
    localparam int CHAR_WIDTH   = 7;
    localparam int NUM_DIGITS   = (VALUE_WIDTH * 77) / 256 + 1;
    localparam int BCD_WIDTH    = 4 * NUM_DIGITS;
    localparam int CNT_WIDTH    = $clog2(VALUE_WIDTH);
    localparam int DIG_WIDTH    = $clog2(NUM_DIGITS + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS   = 7'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE = 7'h0A;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mag;
        logic                   neg;
        logic                   nl;
    } entry_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== sv/i64da_queue.sv =====
// Short register queue between the front and back halves.
// Depends on i64da_pkg and int64_to_decimal_ascii_top_defines.svh.
`default_nettype none
`include "int64_to_decimal_ascii_top_defines.svh"

module i64da_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire i64da_pkg::entry_t        push_entry,
    input  wire logic                     pop,
    output i64da_pkg::entry_t             pop_entry,
    output i64da_pkg::queue_status_t      status
);
    import i64da_pkg::*;

    entry_t                 entries [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0]  wr_ptr_reg;
    logic [QPTR_WIDTH-1:0]  wr_ptr_next;
    logic [QPTR_WIDTH-1:0]  rd_ptr_reg;
    logic [QPTR_WIDTH-1:0]  rd_ptr_next;
    logic [QCNT_WIDTH-1:0]  count_reg;
    logic [QCNT_WIDTH-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QPTR_WIDTH'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QPTR_WIDTH'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry        = entries[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));

    `I64DA_ASSERT_IMP(a_queue_no_overflow, push, !status.full, "push into full queue")
    `I64DA_ASSERT_IMP(a_queue_no_underflow, pop, count_reg != '0, "pop from empty queue")
    `I64DA_ASSERT_NXT(a_queue_count_up, push && !pop,
        count_reg == $past(count_reg) + QCNT_WIDTH'(1), "queue count did not advance")

endmodule

`default_nettype wire

// ===== sv/i64da_front.sv =====
// Front half: accept a transaction, split sign and magnitude, push to the queue.
// Depends on i64da_pkg.
`default_nettype none

module i64da_front (
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [i64da_pkg::INPUT_WIDTH-1:0]    value,
    input  wire logic                                 add_newline,
    input  wire i64da_pkg::queue_status_t             q_status,
    output logic                                      push,
    output i64da_pkg::entry_t                         push_entry
);
    import i64da_pkg::*;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   neg;

    assign raw      = value[VALUE_WIDTH-1:0];
    assign neg      = raw[VALUE_WIDTH-1];
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    assign push_entry.mag = neg ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign push_entry.neg = neg;
    assign push_entry.nl  = add_newline;

endmodule

`default_nettype wire

// ===== sv/i64da_back.sv =====
// Back half: bit-serial binary to BCD conversion and character emission.
// Depends on i64da_pkg and int64_to_decimal_ascii_top_defines.svh.
`default_nettype none
`include "int64_to_decimal_ascii_top_defines.svh"

module i64da_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire i64da_pkg::queue_status_t             q_status,
    input  wire i64da_pkg::entry_t                    pop_entry,
    output logic                                      pop,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [i64da_pkg::CHAR_WIDTH-1:0]          character,
    output logic                                      last
);
    import i64da_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CONV    = 3'd1;
    localparam logic [2:0] ST_SIGN    = 3'd2;
    localparam logic [2:0] ST_DIGITS  = 3'd3;
    localparam logic [2:0] ST_NEWLINE = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic [CNT_WIDTH-1:0]   cnt_next;
    logic [DIG_WIDTH-1:0]   left_reg;
    logic [DIG_WIDTH-1:0]   left_next;
    logic                   started_reg;
    logic                   started_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic [BCD_WIDTH-1:0]   bcd_reg;
    logic [BCD_WIDTH-1:0]   bcd_next;
    logic [BCD_WIDTH-1:0]   bcd_adj;
    logic                   neg_reg;
    logic                   neg_next;
    logic                   nl_reg;
    logic                   nl_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_WIDTH-1:0]  character_reg;
    logic [CHAR_WIDTH-1:0]  character_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   out_load;
    logic                   load_ok;
    logic                   emit_digit;
    logic [3:0]             top_digit;

    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (d inside {[4'd5:4'd15]}) ? d + 4'd3 : d;
        end
    end

    assign top_digit  = bcd_reg[BCD_WIDTH-1 -: 4];
    assign load_ok    = !out_valid_reg || !out_stall;
    assign emit_digit = (top_digit != 4'd0) || started_reg || (left_reg == DIG_WIDTH'(1));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        started_next   = started_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        nl_next        = nl_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        character_next = character_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop        = 1'b1;
                    mag_next   = pop_entry.mag;
                    neg_next   = pop_entry.neg;
                    nl_next    = pop_entry.nl;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCD_WIDTH-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_WIDTH'(1);
                if (cnt_reg == CNT_WIDTH'(VALUE_WIDTH - 1))
                begin
                    left_next    = DIG_WIDTH'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (load_ok)
                begin
                    out_load       = 1'b1;
                    character_next = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (!emit_digit || load_ok)
                begin
                    if (emit_digit)
                    begin
                        out_load       = 1'b1;
                        character_next = CHAR_ZERO + {3'b000, top_digit};
                        last_next      = (left_reg == DIG_WIDTH'(1)) && !nl_reg;
                        started_next   = 1'b1;
                    end
                    bcd_next  = {bcd_reg[BCD_WIDTH-5:0], 4'd0};
                    left_next = left_reg - DIG_WIDTH'(1);
                    if (left_reg == DIG_WIDTH'(1))
                    begin
                        state_next = nl_reg ? ST_NEWLINE : ST_IDLE;
                    end
                end
            end
            ST_NEWLINE:
            begin
                if (load_ok)
                begin
                    out_load       = 1'b1;
                    character_next = CHAR_NEWLINE;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            left_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        neg_reg       <= neg_next;
        nl_reg        <= nl_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    `I64DA_ASSERT_IMP(a_back_digit_bcd, state_reg == ST_DIGITS, top_digit <= 4'd9,
        "digit out of decimal range")
    `I64DA_ASSERT_IMP(a_back_pop_idle, pop, state_reg == ST_IDLE && q_status.not_empty,
        "pop outside idle or from empty queue")
    `I64DA_ASSERT_NXT(a_back_minus_not_last, state_reg == ST_SIGN && load_ok,
        out_valid_reg && !last_reg && character_reg == CHAR_MINUS, "minus sign marked last")

endmodule

`default_nettype wire

// ===== sv/int64_to_decimal_ascii_top.sv =====
// Each transaction carries a signed 64-bit value and a newline flag; the block
// returns its decimal text one ASCII character per output transaction: '-' for
// a negative value, the digits most significant first without leading zeros
// ('0' for zero), then '\n' when asked, with last set on the final character.
// The back end takes one item at a time: it fetches the item from the queue,
// runs a shift-and-adjust binary to BCD conversion over all 64 bits, then
// steps through the decimal positions (20 of them, leading zeros dropped
// without output), with a step for the sign and another for the newline when
// present. A two-entry queue lets the input take two more items while one is
// being converted.
`default_nettype none

module int64_to_decimal_ascii_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [i64da_pkg::INPUT_WIDTH-1:0]    value,
    input  wire logic                                 add_newline,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [i64da_pkg::CHAR_WIDTH-1:0]          character,
    output logic                                      last
);
    import i64da_pkg::*;

    queue_status_t q_status;
    entry_t        push_entry;
    entry_t        pop_entry;
    logic          push;
    logic          pop;

    i64da_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .add_newline (add_newline),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    i64da_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    i64da_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== test/int64_to_decimal_ascii_top_tb.sv =====
// Self-checking testbench for int64_to_decimal_ascii_top: signed values go in,
// decimal ASCII text comes out one character per transaction, checked in order.
// Depends on i64da_pkg and the block under test; nothing else.
`timescale 1ns / 1ps

module int64_to_decimal_ascii_top_tb;

    import i64da_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          RESET_CYCLES  = 6;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          DRAIN_CYCLES  = 200;
    localparam int          MAX_PRINTED   = 100;
    localparam int          MAX_DEC_DIGITS = 20;
    localparam logic [63:0] DECIMAL_RADIX = 64'd10;
    localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  last;
    } text_char_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [INPUT_WIDTH-1:0] value;
    logic                   add_newline;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [CHAR_WIDTH-1:0]  character;
    logic                   last;

    text_char_t expected_text [$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;
    int         stall_pct      = 0;

    int64_to_decimal_ascii_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .add_newline (add_newline),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Build the expected text of one value and append it to the expected queue.
    function automatic void queue_decimal_text(input logic [63:0] raw, input logic nl);
        logic [63:0] magnitude;
        logic [3:0]  digit_buf [MAX_DEC_DIGITS];
        logic        negative;
        int          num_digits;
        int          total;
        int          k;
        text_char_t  entry;
        negative   = raw[63];
        magnitude  = negative ? (~raw + 64'd1) : raw;
        num_digits = 0;
        do
        begin
            digit_buf[num_digits] = 4'(magnitude % DECIMAL_RADIX);
            magnitude             = magnitude / DECIMAL_RADIX;
            num_digits++;
        end
        while (magnitude != 64'd0 && num_digits < MAX_DEC_DIGITS);
        total = (negative ? 1 : 0) + num_digits + (nl ? 1 : 0);
        k = 0;
        if (negative)
        begin
            entry.character = CHAR_MINUS;
            entry.last      = (k == total - 1);
            expected_text.push_back(entry);
            k++;
        end
        for (int i = num_digits - 1; i >= 0; i--)
        begin
            entry.character = CHAR_ZERO + CHAR_WIDTH'(digit_buf[i]);
            entry.last      = (k == total - 1);
            expected_text.push_back(entry);
            k++;
        end
        if (nl)
        begin
            entry.character = CHAR_NEWLINE;
            entry.last      = 1'b1;
            expected_text.push_back(entry);
        end
    endfunction

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_value(input logic [63:0] v, input logic nl);
        logic accepted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        value       <= v;
        add_newline <= nl;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = !in_stall;
            @(posedge clk);
        end
        queue_decimal_text(v, nl);
    endtask

    // Sample mid-cycle: a character seen here is taken at the next rising edge.
    always @(negedge clk)
    begin : check_text
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_text.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %h last %b",
                                          character, last));
            end
            else
            begin
                want = expected_text.pop_front();
                if (character !== want.character)
                    report_mismatch($sformatf("character %h, want %h",
                                              character, want.character));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, want %b on character %h",
                                              last, want.last, want.character));
            end
        end
    end

    task automatic test_extremes();
        send_value(64'd0, 1'b0);
        send_value(64'd0, 1'b1);
        send_value(64'd1, 1'b0);
        send_value(-64'sd1, 1'b1);
        send_value(64'd9, 1'b1);
        send_value(-64'sd9, 1'b0);
        send_value(64'd10, 1'b0);
        send_value(-64'sd10, 1'b1);
        send_value(64'd99, 1'b0);
        send_value(64'd100, 1'b1);
        send_value(-64'sd100, 1'b0);
        send_value(MOST_POSITIVE, 1'b0);
        send_value(MOST_POSITIVE, 1'b1);
        send_value(MOST_NEGATIVE, 1'b0);
        send_value(MOST_NEGATIVE, 1'b1);
        send_value(MOST_NEGATIVE + 64'd1, 1'b1);
        send_value(64'd1000000000000000000, 1'b0);
        send_value(64'd999999999999999999, 1'b1);
        send_value(-64'sd1000000000000000000, 1'b1);
        send_value(64'h5555_5555_5555_5555, 1'b0);
        send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_value(64'h8000_0000_0000_0001, 1'b0);
        send_value(64'd4294967296, 1'b1);
    endtask

    // Values of every decimal length, with a bias toward powers of ten.
    task automatic test_digit_lengths(input int count);
        logic [63:0] low_bound;
        logic [63:0] magnitude;
        int          num_digits;
        for (int n = 0; n < count; n++)
        begin
            num_digits = $urandom_range(19, 1);
            low_bound  = 64'd1;
            for (int d = 1; d < num_digits; d++)
                low_bound = low_bound * DECIMAL_RADIX;
            if ($urandom_range(3) == 0)
                magnitude = low_bound + 64'($urandom_range(2)) - 64'd1;
            else
                magnitude = low_bound + ({$urandom, $urandom} % (low_bound * 64'd9));
            if (num_digits == 1 && $urandom_range(4) == 0)
                magnitude = 64'd0;
            send_value($urandom_range(1) ? (~magnitude + 64'd1) : magnitude,
                       1'($urandom_range(1)));
        end
    endtask

    task automatic test_full_range(input int count);
        for (int n = 0; n < count; n++)
            send_value({$urandom, $urandom}, 1'($urandom_range(1)));
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_rate);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        test_digit_lengths(55);
        test_full_range(50);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        value       <= '0;
        add_newline <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        run_random_phase(0, 0);
        run_random_phase(57, 0);
        run_random_phase(0, 57);
        run_random_phase(36, 36);

        in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
